// File: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the stride class picker
// Class and count widths, register indexes, command codes, sequencer states
// and the queue rebuild function.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int COUNT_W     = 32;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int LEN_W       = $clog2(NUM_CLASSES + 1);
    localparam int STRIDE_W    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVER_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 3'd5;

    // command codes
    localparam logic CMD_PICK     = 1'b0;
    localparam logic CMD_ACTIVATE = 1'b1;

    typedef logic [CLASS_W-1:0] t_cls;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT,
        ST_HEAD,
        ST_TAIL,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_cls [NUM_CLASSES-1:0] order;
        logic [LEN_W-1:0]       len;
    } t_queue_init;

    // Queue of present classes, highest index at the head.
    function automatic t_queue_init build_queue(input logic [NUM_CLASSES-1:0] mask);
        t_queue_init      r;
        logic [LEN_W-1:0] n;
        r = '0;
        n = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (mask[i]) begin
                r.order[n[CLASS_W-1:0]] = CLASS_W'(i);
                n = n + 1'b1;
            end
        end
        r.len = n;
        return r;
    endfunction

endpackage

// File: rtl/stride_class_picker.sv
// ----------------------------------------------------------------------------
// stride_class_picker: stride scheduling arbiter over four scheduler classes
// Keeps a pass-count ordered queue of classes and answers pick and activate
// requests one at a time with a small sequencer around one shared adder.
// ----------------------------------------------------------------------------
// A pick transfer walks the queue from the head: an idle ordinary class is
// rotated to the tail with the tail's count plus one, an idle driver class
// has its stride added and is dropped, and the first ready class gets its
// stride added and is reinserted in count order (wrap-aware signed compare).
// A lone queued class is returned unchanged when ready. When nothing is ready
// within one pass the result flags no_work. An activate transfer puts a
// dropped driver class back at the head with the head's count. All count
// arithmetic, the stride add, the tail-plus-one and every ordering compare,
// goes through one 32-bit adder, one use per cycle. An activate passes the
// ACT and EMIT states; a pick passes HEAD for each popped class, TAIL for
// each rotated class and SEARCH for each ordering compare, then EMIT.
// Results sit in an output register, so the next item is taken while a
// result still waits. Writing present_mask rebuilds the queue and clears all
// counts and dropped flags.
// ----------------------------------------------------------------------------
module stride_class_picker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [scp_pkg::NUM_CLASSES-1:0]  i_ready_mask,
    input  logic [scp_pkg::CLASS_W-1:0]      i_class_id,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [scp_pkg::CLASS_W-1:0]      o_chosen_class,
    output logic                             o_no_work,
    output logic                             o_reactivated
);

    localparam int N  = scp_pkg::NUM_CLASSES;
    localparam int CW = scp_pkg::CLASS_W;
    localparam int LW = scp_pkg::LEN_W;
    localparam int KW = scp_pkg::COUNT_W;

    scp_pkg::t_state r_state, n_state;

    // queue and class state
    scp_pkg::t_cls                 r_q [N];
    logic [LW-1:0]                 r_len;
    scp_pkg::t_count               r_pc [N];
    logic [N-1:0]                  r_drop;

    // configuration
    logic [scp_pkg::STRIDE_W-1:0]  r_stride [N];
    logic [N-1:0]                  r_drv;

    // work registers of the current item
    logic [N-1:0]                  r_ready;
    scp_pkg::t_cls                 r_cls;
    logic [LW-1:0]                 r_left;
    scp_pkg::t_cls                 r_idx;
    scp_pkg::t_count               r_cnt;
    scp_pkg::t_cls                 r_res_cls;
    logic                          r_res_nw;
    logic                          r_res_re;

    // output register
    logic                          r_ov;
    scp_pkg::t_cls                 r_o_cls;
    logic                          r_o_nw;
    logic                          r_o_re;

    // shared unit controls and datapath
    scp_pkg::t_cls                 rd_pos;
    scp_pkg::t_count               add_b;
    logic                          add_cin;
    scp_pkg::t_cls                 rd_cls;
    scp_pkg::t_count               rd_cnt;
    scp_pkg::t_count               sum;
    logic                          after;
    logic                          in_xfer;
    logic                          out_free;
    logic                          search_hit;
    scp_pkg::t_queue_init          rb_reset;
    scp_pkg::t_queue_init          rb_cfg;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;

    // one read of the queue and one read of the counts per cycle
    assign rd_cls = r_q[rd_pos];
    assign rd_cnt = r_pc[rd_cls];

    // the shared adder: stride add, tail plus one, or count difference
    assign sum   = rd_cnt + add_b + KW'(add_cin);
    // entry belongs behind the picked class when the difference is positive
    assign after = (sum != '0) && !sum[KW-1];

    assign search_hit = ({1'b0, r_idx} == LW'(r_len)) || after;

    assign rb_reset = scp_pkg::build_queue({N{1'b1}});
    assign rb_cfg   = scp_pkg::build_queue(i_cfg_data[N-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scp_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_cmd == scp_pkg::CMD_ACTIVATE) ? scp_pkg::ST_ACT
                                                               : scp_pkg::ST_HEAD;
                end
            end
            scp_pkg::ST_ACT: n_state = scp_pkg::ST_EMIT;
            scp_pkg::ST_HEAD: begin
                if (r_left == '0 || r_len <= LW'(1)) begin
                    n_state = scp_pkg::ST_EMIT;
                end else if (!r_ready[rd_cls]) begin
                    n_state = r_drv[rd_cls] ? scp_pkg::ST_HEAD : scp_pkg::ST_TAIL;
                end else begin
                    n_state = scp_pkg::ST_SEARCH;
                end
            end
            scp_pkg::ST_TAIL: n_state = scp_pkg::ST_HEAD;
            scp_pkg::ST_SEARCH: begin
                if (search_hit) n_state = scp_pkg::ST_EMIT;
            end
            scp_pkg::ST_EMIT: begin
                if (out_free) n_state = scp_pkg::ST_IDLE;
            end
            default: n_state = scp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: stall and shared unit operand selection
    always_comb begin
        o_in_stall = 1'b1;
        rd_pos     = '0;
        add_b      = '0;
        add_cin    = 1'b0;
        unique case (r_state)
            scp_pkg::ST_IDLE: o_in_stall = 1'b0;
            scp_pkg::ST_ACT:  rd_pos = '0;
            scp_pkg::ST_HEAD: begin
                rd_pos = '0;
                add_b  = KW'(r_stride[r_q[0]]);
            end
            scp_pkg::ST_TAIL: begin
                rd_pos  = CW'(r_len - 1'b1);
                add_cin = 1'b1;
            end
            scp_pkg::ST_SEARCH: begin
                rd_pos  = r_idx;
                add_b   = ~r_cnt;
                add_cin = 1'b1;
            end
            scp_pkg::ST_EMIT: rd_pos = '0;
            default:          rd_pos = '0;
        endcase
    end

    // state, queue and count updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scp_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_len   <= rb_reset.len;
            r_drop  <= '0;
            r_drv   <= '0;
            for (int j = 0; j < N; j++) begin
                r_q[j]      <= rb_reset.order[j];
                r_pc[j]     <= '0;
                r_stride[j] <= scp_pkg::STRIDE_W'(1);
            end
        end else begin
            r_state <= n_state;
            // load a finished result, or drop one that has been taken
            if (r_state == scp_pkg::ST_EMIT && out_free) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall)              r_ov <= 1'b0;

            unique case (r_state)
                scp_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        r_ready   <= i_ready_mask;
                        r_cls     <= i_class_id;
                        r_left    <= r_len;
                        r_res_cls <= '0;
                        r_res_nw  <= 1'b0;
                        r_res_re  <= 1'b0;
                    end
                end
                scp_pkg::ST_ACT: begin
                    // reinsert a dropped class at the head with the head's count
                    if (r_drop[r_cls] && r_len < LW'(N)) begin
                        r_drop[r_cls] <= 1'b0;
                        if (r_len != '0) r_pc[r_cls] <= rd_cnt;
                        for (int j = 1; j < N; j++) r_q[j] <= r_q[j-1];
                        r_q[0]   <= r_cls;
                        r_len    <= r_len + 1'b1;
                        r_res_re <= 1'b1;
                    end
                end
                scp_pkg::ST_HEAD: begin
                    if (r_left == '0 || r_len == '0) begin
                        r_res_nw <= 1'b1;
                    end else if (r_len == LW'(1)) begin
                        // lone class: return it when ready, count untouched
                        if (r_ready[rd_cls]) r_res_cls <= rd_cls;
                        else                 r_res_nw  <= 1'b1;
                    end else begin
                        // pop the head and add its stride
                        for (int j = 0; j < N - 1; j++) r_q[j] <= r_q[j+1];
                        r_len        <= r_len - 1'b1;
                        r_cls        <= rd_cls;
                        r_pc[rd_cls] <= sum;
                        r_cnt        <= sum;
                        r_idx        <= '0;
                        if (!r_ready[rd_cls] && r_drv[rd_cls]) begin
                            r_drop[rd_cls] <= 1'b1;
                            r_left         <= r_left - 1'b1;
                        end
                    end
                end
                scp_pkg::ST_TAIL: begin
                    // rotate an idle class to the tail, one past the tail's count
                    r_pc[r_cls]          <= sum;
                    r_q[r_len[CW-1:0]]   <= r_cls;
                    r_len                <= r_len + 1'b1;
                    r_left               <= r_left - 1'b1;
                end
                scp_pkg::ST_SEARCH: begin
                    if (search_hit) begin
                        for (int j = 1; j < N; j++) begin
                            if (CW'(j) > r_idx) r_q[j] <= r_q[j-1];
                        end
                        r_q[r_idx] <= r_cls;
                        r_len      <= r_len + 1'b1;
                        r_res_cls  <= r_cls;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                scp_pkg::ST_EMIT: begin
                    if (out_free) begin
                        r_o_cls <= r_res_cls;
                        r_o_nw  <= r_res_nw;
                        r_o_re  <= r_res_re;
                    end
                end
                default: ;
            endcase

            // the user must write configuration only while idle; the block does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    scp_pkg::REG_STRIDE_0: r_stride[0] <= i_cfg_data;
                    scp_pkg::REG_STRIDE_1: r_stride[1] <= i_cfg_data;
                    scp_pkg::REG_STRIDE_2: r_stride[2] <= i_cfg_data;
                    scp_pkg::REG_STRIDE_3: r_stride[3] <= i_cfg_data;
                    scp_pkg::REG_DRIVER_MASK: r_drv <= i_cfg_data[N-1:0];
                    scp_pkg::REG_PRESENT_MASK: begin
                        // rebuild the queue, clear counts and dropped flags
                        r_len  <= rb_cfg.len;
                        r_drop <= '0;
                        for (int j = 0; j < N; j++) begin
                            r_q[j]  <= rb_cfg.order[j];
                            r_pc[j] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_chosen_class = r_o_cls;
    assign o_no_work      = r_o_nw;
    assign o_reactivated  = r_o_re;

endmodule

// File: rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_port_checks: port-level checks of the stride class picker
// Watches the top-level ports only and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module scp_port_checks (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic [scp_pkg::CLASS_W-1:0]      o_chosen_class,
    input  logic                             o_no_work,
    input  logic                             o_reactivated
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: busy right after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is at work");

    // a fresh result comes out of the sequencer, never while idle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // no work and reactivate results carry class zero and exclude each other
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_no_work || o_reactivated) |->
            (o_chosen_class == '0) && !(o_no_work && o_reactivated))
        else $error("inconsistent result fields");

endmodule

bind stride_class_picker scp_port_checks u_scp_port_checks (.*);
